[design/next_fit_block_allocator_macros.svh]
// Assertion helpers used by the checker file.
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define NFBA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nfba assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define NFBA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nfba assertion failed");

`endif

[design/nfba_pkg.sv]
`timescale 1ns / 1ps

package nfba_pkg;

   // Field widths of the request and response beats.
   localparam int ACTION_W = 1;
   localparam int INDEX_W  = 4;
   localparam int AMOUNT_W = 16;
   localparam int COUNT_W  = 5;
   localparam int NUMBER_W = 16;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b1;

   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                valid;
      logic                granted;
      logic [INDEX_W-1:0]  granted_block;
      logic [NUMBER_W-1:0] request_number;
   } result_type;

endpackage

[design/nfba_req_if.sv]
`timescale 1ns / 1ps

interface nfba_req_if;
   logic                          valid;
   logic                          ready;
   logic [nfba_pkg::ACTION_W-1:0] action;
   logic [nfba_pkg::INDEX_W-1:0]  block_index;
   logic [nfba_pkg::AMOUNT_W-1:0] amount;

   modport source (output valid, action, block_index, amount, input ready);
   modport sink   (input valid, action, block_index, amount, output ready);
endinterface

[design/nfba_rsp_if.sv]
`timescale 1ns / 1ps

interface nfba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          granted;
   logic [nfba_pkg::INDEX_W-1:0]  granted_block;
   logic [nfba_pkg::NUMBER_W-1:0] request_number;

   modport source (output valid, granted, granted_block, request_number, input ready);
   modport sink   (input valid, granted, granted_block, request_number, output ready);
endinterface

[design/nfba_ram.sv]
`timescale 1ns / 1ps

module nfba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/nfba_engine.sv]
`timescale 1ns / 1ps

module nfba_engine #(
   parameter int MAX_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   nfba_req_if.sink                          req,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0]   eff_count,
   input  logic                              res_ready,
   output nfba_pkg::result_type              res
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   nfba_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]              rover_ff;
   logic [nfba_pkg::NUMBER_W-1:0] reqnum_ff;
   logic [IDX_W-1:0]              pos_ff;
   logic [IDX_W-1:0]              start_ff;
   logic [CNT_W-1:0]              k_ff;
   logic [SIZE_BITS-1:0]          amount_ff;
   logic                          granted_ff;
   logic [nfba_pkg::INDEX_W-1:0]  block_ff;

   logic                 accept, is_load, is_alloc, idx_ok;
   logic [SIZE_BITS-1:0] amount_sz;
   logic [IDX_W-1:0]     start_pos, pos_next;
   logic                 fits, last;

   logic                 wr_en, rd_en;
   logic [IDX_W-1:0]     wr_addr, rd_addr;
   logic [SIZE_BITS-1:0] wr_data, rd_data;

   assign accept    = req.valid && req.ready;
   assign is_load   = accept && (req.action == nfba_pkg::ACT_LOAD);
   assign is_alloc  = accept && (req.action == nfba_pkg::ACT_ALLOC);
   assign idx_ok    = 32'(req.block_index) < 32'(MAX_BLOCKS);
   assign amount_sz = SIZE_BITS'(req.amount);

   // Restart from block 0 when the count no longer covers the rover's block.
   assign start_pos = (CNT_W'(rover_ff) < eff_count) ? rover_ff : '0;
   assign pos_next  = ((CNT_W'(pos_ff) + CNT_W'(1)) == eff_count) ? '0
                                                                 : pos_ff + IDX_W'(1);
   assign fits      = rd_data >= amount_ff;
   assign last      = (k_ff + CNT_W'(1)) == eff_count;

   nfba_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (MAX_BLOCKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nfba_pkg::ST_IDLE: begin
            if (is_alloc) begin
               state_in = nfba_pkg::ST_SCAN;
            end
         end
         nfba_pkg::ST_SCAN: begin
            if (fits || last) begin
               state_in = nfba_pkg::ST_DONE;
            end
         end
         nfba_pkg::ST_DONE: begin
            if (res_ready) begin
               state_in = nfba_pkg::ST_IDLE;
            end
         end
         default: state_in = nfba_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = rd_data - amount_ff;
      rd_en     = 1'b0;
      rd_addr   = pos_next;
      unique case (state_ff)
         nfba_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            wr_en     = is_load && idx_ok;
            wr_addr   = IDX_W'(req.block_index);
            wr_data   = amount_sz;
            rd_en     = is_alloc;
            rd_addr   = start_pos;
         end
         nfba_pkg::ST_SCAN: begin
            // Write back on a hit, otherwise fetch the next block unless this was the last.
            wr_en = fits;
            rd_en = !fits && !last;
         end
         nfba_pkg::ST_DONE: begin
            req.ready = 1'b0;
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   assign res.valid          = (state_ff == nfba_pkg::ST_DONE);
   assign res.granted        = granted_ff;
   assign res.granted_block  = block_ff;
   assign res.request_number = reqnum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= nfba_pkg::ST_IDLE;
         rover_ff  <= '0;
         reqnum_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (is_alloc) begin
            reqnum_ff <= reqnum_ff + nfba_pkg::NUMBER_W'(1);
         end
         if (state_ff == nfba_pkg::ST_SCAN) begin
            if (fits) begin
               rover_ff <= pos_ff;
            end else if (last) begin
               rover_ff <= start_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (is_alloc) begin
         amount_ff <= amount_sz;
         pos_ff    <= start_pos;
         start_ff  <= start_pos;
         k_ff      <= '0;
      end else if (state_ff == nfba_pkg::ST_SCAN) begin
         if (fits) begin
            granted_ff <= 1'b1;
            block_ff   <= nfba_pkg::INDEX_W'(pos_ff);
         end else if (last) begin
            granted_ff <= 1'b0;
            block_ff   <= '0;
         end else begin
            pos_ff <= pos_next;
            k_ff   <= k_ff + CNT_W'(1);
         end
      end
   end

endmodule

[design/next_fit_block_allocator.sv]
// Next-fit block allocator. A load beat writes one block's free size into the
// table and returns nothing. An allocate beat scans the table from the rover,
// wrapping at the block count, one table read per cycle, grants the first block
// with enough room, reduces it by the request and parks the rover there; on a
// miss the rover returns to the block the scan started from. Every allocate beat
// returns one response beat with its sequence number. An allocate first issues
// the read of its start block, then examines the blocks in turn (at most the
// block count) through the table's registered read port, and then hands the
// result to the output register once that can take it. The table needs no clearing
// after reset; only loaded blocks may be allocated from. Write the block count only while idle.
`timescale 1ns / 1ps

module next_fit_block_allocator #(
   parameter int MAX_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   nfba_req_if.sink                      req_chan,
   nfba_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [nfba_pkg::COUNT_W-1:0]  csr_wdata
);

   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   logic [nfba_pkg::COUNT_W-1:0]  csr_count_ff;
   logic [CNT_W-1:0]              eff_count;

   nfba_pkg::result_type          res;
   logic                          res_ready;
   logic                          rsp_valid_ff;
   logic                          rsp_granted_ff;
   logic [nfba_pkg::INDEX_W-1:0]  rsp_block_ff;
   logic [nfba_pkg::NUMBER_W-1:0] rsp_number_ff;

   // Hold the block count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff <= nfba_pkg::BLOCK_COUNT_RESET;
      end else if (csr_we) begin
         csr_count_ff <= csr_wdata;
      end
   end

   // Clamp the count: zero acts as one, anything past the table as the table size.
   always_comb begin
      if (32'(csr_count_ff) > 32'(MAX_BLOCKS)) begin
         eff_count = CNT_W'(MAX_BLOCKS);
      end else if (csr_count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else begin
         eff_count = CNT_W'(csr_count_ff);
      end
   end

   nfba_engine #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .eff_count (eff_count),
      .res_ready (res_ready),
      .res       (res)
   );

   // Output register: take a new result when empty or draining this cycle.
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res.valid) begin
         rsp_granted_ff <= res.granted;
         rsp_block_ff   <= res.granted_block;
         rsp_number_ff  <= res.request_number;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.granted        = rsp_granted_ff;
   assign rsp_chan.granted_block  = rsp_block_ff;
   assign rsp_chan.request_number = rsp_number_ff;

endmodule

[design/nfba_checker.sv]
`timescale 1ns / 1ps
`include "next_fit_block_allocator_macros.svh"

module nfba_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [nfba_pkg::ACTION_W-1:0] req_action,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_granted,
   input logic [nfba_pkg::INDEX_W-1:0]  rsp_granted_block,
   input logic [nfba_pkg::NUMBER_W-1:0] rsp_request_number
);

   logic                          seen_ff;
   logic [nfba_pkg::NUMBER_W-1:0] last_number_ff;
   logic                          rsp_beat, alloc_beat;

   assign rsp_beat   = rsp_valid && rsp_ready;
   assign alloc_beat = req_valid && req_ready && (req_action == nfba_pkg::ACT_ALLOC);

   // Track the number of the last delivered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff        <= 1'b0;
         last_number_ff <= '0;
      end else if (rsp_beat) begin
         seen_ff        <= 1'b1;
         last_number_ff <= rsp_request_number;
      end
   end

   `NFBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_granted_block) && $stable(rsp_granted) && $stable(rsp_request_number))
   `NFBA_ASSERT_NOW(a_miss_block_zero, rsp_valid && !rsp_granted, rsp_granted_block == '0)
   `NFBA_ASSERT_NOW(a_number_steps, rsp_beat && seen_ff, rsp_request_number == last_number_ff + nfba_pkg::NUMBER_W'(1))
   `NFBA_ASSERT_NEXT(a_alloc_blocks_req, alloc_beat, !req_ready)

endmodule

bind next_fit_block_allocator nfba_checker u_nfba_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_action         (req_chan.action),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_granted        (rsp_chan.granted),
   .rsp_granted_block  (rsp_chan.granted_block),
   .rsp_request_number (rsp_chan.request_number)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int TABLE_SIZE      = 16;
   // Settle time after a drain; leave ample room for the longest allocate.
   localparam int SETTLE_CYCLES   = 40;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AT     = 60;
   localparam int PHASES          = 9;
   localparam int BEATS_PER_PHASE = 75;

   typedef struct {
      logic [nfba_pkg::ACTION_W-1:0] action;
      logic [nfba_pkg::INDEX_W-1:0]  block_index;
      logic [nfba_pkg::AMOUNT_W-1:0] amount;
   } beat_type;

   typedef struct {
      logic                          granted;
      logic [nfba_pkg::INDEX_W-1:0]  granted_block;
      logic [nfba_pkg::NUMBER_W-1:0] request_number;
   } grant_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_we;
   logic [nfba_pkg::COUNT_W-1:0] csr_wdata;

   nfba_req_if req ();
   nfba_rsp_if rsp ();

   next_fit_block_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the allocator: free sizes, rover, request sequence, block count.
   logic [nfba_pkg::AMOUNT_W-1:0] free_size [TABLE_SIZE];
   logic [nfba_pkg::INDEX_W-1:0]  rover_pos;
   logic [nfba_pkg::NUMBER_W-1:0] alloc_seq;
   logic [nfba_pkg::COUNT_W-1:0]  blocks_in_use;

   beat_type  beats_pending [$];     // request beats waiting to be driven
   grant_type grants_due [$];        // responses owed by the allocator, oldest first

   bit steady;                       // no idling on either side while set
   bit hold_done     = 1'b0;
   int cycle_count   = 0;
   int beats_sent    = 0;
   int grants_seen   = 0;
   int misses_seen   = 0;
   int mismatches    = 0;
   int hold_left     = 0;
   int settings_used = 0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Next-fit scan over the shadow table; updates rover, sequence and free size.
   function automatic grant_type next_fit_grant(logic [nfba_pkg::AMOUNT_W-1:0] want);
      grant_type g;
      int        span;
      int        pos;
      span = (blocks_in_use == 0) ? 1 :
             (blocks_in_use > TABLE_SIZE) ? TABLE_SIZE : int'(blocks_in_use);
      // A rover left outside a lowered count restarts the scan at block zero.
      pos = (rover_pos < span) ? int'(rover_pos) : 0;
      alloc_seq = alloc_seq + 1'b1;
      g.granted        = 1'b0;
      g.granted_block  = '0;
      g.request_number = alloc_seq;
      for (int k = 0; k < span && !g.granted; k++) begin
         if (free_size[pos[nfba_pkg::INDEX_W-1:0]] >= want) begin
            free_size[pos[nfba_pkg::INDEX_W-1:0]] =
               free_size[pos[nfba_pkg::INDEX_W-1:0]] - want;
            g.granted       = 1'b1;
            g.granted_block = pos[nfba_pkg::INDEX_W-1:0];
         end else begin
            pos = (pos + 1 == span) ? 0 : pos + 1;
         end
      end
      // A miss walks the full circle, so the rover lands back on its start.
      rover_pos = pos[nfba_pkg::INDEX_W-1:0];
      return g;
   endfunction

   task automatic queue_beat(logic [nfba_pkg::ACTION_W-1:0] action,
                             logic [nfba_pkg::INDEX_W-1:0]  index,
                             logic [nfba_pkg::AMOUNT_W-1:0] amount);
      beat_type b;
      b.action      = action;
      b.block_index = index;
      b.amount      = amount;
      beats_pending.push_back(b);
   endtask

   // Hold until every beat is sent and answered, then let the last load settle.
   task automatic wait_idle();
      do @(negedge clock);
      while (beats_pending.size() != 0 || req.valid || grants_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the block count; call only while the allocator is idle.
   task automatic write_block_count(logic [nfba_pkg::COUNT_W-1:0] value);
      @(posedge clock);
      csr_we        <= 1'b1;
      csr_wdata     <= value;
      blocks_in_use  = value;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Request driver: predict on every accepted beat, then pick the next one.
   always @(posedge clock) begin
      beat_type nxt;
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            beats_sent++;
            if (req.action == nfba_pkg::ACT_LOAD) begin
               free_size[req.block_index] = req.amount;
            end else begin
               grants_due.push_back(next_fit_grant(req.amount));
            end
         end
         // Advance only when the current beat is gone; otherwise hold it.
         if (!req.valid || req.ready) begin
            if (beats_pending.size() != 0 && (steady || $urandom_range(0, 99) >= 35)) begin
               nxt              = beats_pending.pop_front();
               req.valid       <= 1'b1;
               req.action      <= nxt.action;
               req.block_index <= nxt.block_index;
               req.amount      <= nxt.amount;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Once, block the output long enough for the allocator to back up.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && grants_seen + misses_seen >= HOLD_OFF_AT) begin
         hold_left <= HOLD_OFF_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // Response monitor: check each beat against the oldest prediction.
   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (grants_due.size() == 0) begin
               $error("response beat with no allocate outstanding");
               mismatches++;
            end else begin
               want = grants_due.pop_front();
               if (rsp.granted !== want.granted) begin
                  $error("granted: expected %0d, got %0d", want.granted, rsp.granted);
                  mismatches++;
               end
               if (rsp.granted_block !== want.granted_block) begin
                  $error("granted_block: expected %0d, got %0d",
                         want.granted_block, rsp.granted_block);
                  mismatches++;
               end
               if (rsp.request_number !== want.request_number) begin
                  $error("request_number: expected %0d, got %0d",
                         want.request_number, rsp.request_number);
                  mismatches++;
               end
               if (want.granted) grants_seen++;
               else misses_seen++;
            end
         end
         if (hold_left > 0) begin
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= steady || ($urandom_range(0, 99) >= 35);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      logic [nfba_pkg::COUNT_W-1:0]  cnt;
      logic [nfba_pkg::AMOUNT_W-1:0] amt;

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      req.valid       = 1'b0;
      req.action      = nfba_pkg::ACT_LOAD;
      req.block_index = '0;
      req.amount      = '0;
      rsp.ready       = 1'b0;
      steady          = 1'b0;
      rover_pos       = '0;
      alloc_seq       = '0;
      blocks_in_use   = nfba_pkg::BLOCK_COUNT_RESET;
      for (int i = 0; i < TABLE_SIZE; i++) free_size[i] = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_block_count(5'd16);
      @(negedge clock);

      // Load every block before any allocate so no scan reads an unwritten entry.
      for (int i = 0; i < TABLE_SIZE - 1; i++) begin
         queue_beat(nfba_pkg::ACT_LOAD, nfba_pkg::INDEX_W'(i), nfba_pkg::AMOUNT_W'(i * 16));
      end
      queue_beat(nfba_pkg::ACT_LOAD, 4'd15, 16'hFFFF);
      // Zero request takes the rover's block even when it is empty.
      queue_beat(nfba_pkg::ACT_ALLOC, 4'd0, 16'd0);
      // Skip an empty block.
      queue_beat(nfba_pkg::ACT_ALLOC, 4'd9, 16'd1);
      // Largest request: only the full block fits, rover moves to the top block.
      queue_beat(nfba_pkg::ACT_ALLOC, 4'd0, 16'hFFFF);
      // Nothing fits: miss, rover stays.
      queue_beat(nfba_pkg::ACT_ALLOC, 4'd15, 16'hFFFF);
      // Wrap past the last block back to the bottom of the table.
      queue_beat(nfba_pkg::ACT_ALLOC, 4'd3, 16'd200);
      // Refill the top block and hit it again, scanning forward from the rover.
      queue_beat(nfba_pkg::ACT_LOAD, 4'd15, 16'hFFFF);
      queue_beat(nfba_pkg::ACT_ALLOC, 4'd0, 16'hFFFF);
      wait_idle();

      // Random phases over several block counts, extremes and out-of-range included.
      // Dropping to one block right after the directed part strands the rover.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       cnt = 5'd1;
            1:       cnt = 5'd0;
            2:       cnt = 5'd31;
            3:       cnt = 5'd2;
            4:       cnt = 5'd17;
            5:       cnt = 5'd3;
            6:       cnt = 5'd16;
            7:       cnt = nfba_pkg::COUNT_W'($urandom_range(4, 15));
            default: cnt = nfba_pkg::COUNT_W'($urandom_range(0, 31));
         endcase
         write_block_count(cnt);
         @(negedge clock);
         steady = (phase == 3);
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            // Pause the sender mid-phase until every response is back.
            if (n == BEATS_PER_PHASE / 2) wait_idle();
            case ($urandom_range(0, 9))
               0, 1, 2, 3: amt = nfba_pkg::AMOUNT_W'($urandom_range(0, 63));
               4, 5, 6:    amt = nfba_pkg::AMOUNT_W'($urandom_range(0, 4095));
               7, 8:       amt = nfba_pkg::AMOUNT_W'($urandom_range(0, 65535));
               default:    amt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            endcase
            if ($urandom_range(0, 99) < 40) begin
               // Loads lean large so the table keeps refilling.
               if ($urandom_range(0, 1)) amt = nfba_pkg::AMOUNT_W'($urandom_range(0, 65535));
               queue_beat(nfba_pkg::ACT_LOAD,
                          nfba_pkg::INDEX_W'($urandom_range(0, 15)), amt);
            end else begin
               queue_beat(nfba_pkg::ACT_ALLOC,
                          nfba_pkg::INDEX_W'($urandom_range(0, 15)), amt);
            end
         end
         wait_idle();
         steady = 1'b0;
      end

      $display("tb_top: %0d request beats, %0d grants and %0d misses checked",
               beats_sent, grants_seen, misses_seen);
      $display("tb_top: %0d block-count settings, one long output stall", settings_used);
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
